// ----- sv/slpg_pkg.sv -----
// ----------------------------------------------------------------------------
// Status LED pattern generator package
// Shared types, widths and codes for the pattern generator and its divider.
// ----------------------------------------------------------------------------
package slpg_pkg;

    // Event kinds carried by an input transfer.
    localparam logic [1:0] KIND_TICK     = 2'd0;
    localparam logic [1:0] KIND_LINK     = 2'd1;
    localparam logic [1:0] KIND_CONV     = 2'd2;
    localparam logic [1:0] KIND_COMPLETE = 2'd3;

    // Indicator modes.
    localparam logic [1:0] MODE_DISC   = 2'd0;
    localparam logic [1:0] MODE_CONN   = 2'd1;
    localparam logic [1:0] MODE_ACTIVE = 2'd2;
    localparam logic [1:0] MODE_ERROR  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_ON   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_OFF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PAUSE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_FLASH_CNT  = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [9:0]  RST_STEP       = 10'd50;
    localparam logic [7:0]  RST_BRIGHTNESS = 8'd102;
    localparam logic [15:0] RST_BLINK      = 16'd800;
    localparam logic [15:0] RST_PULSE      = 16'd1200;
    localparam logic [15:0] RST_FLASH_ON   = 16'd200;
    localparam logic [15:0] RST_FLASH_OFF  = 16'd150;
    localparam logic [15:0] RST_PAUSE      = 16'd2000;
    localparam logic [3:0]  RST_FLASH_CNT  = 4'd3;

    localparam logic [7:0] MIN_GLOW = 8'd10;

    // Divider geometry: the dividend is the elapsed time, the divisor is at
    // most one full error cycle (15 * 131070 + 65535 < 2^21).
    localparam int DVD_W      = 32;
    localparam int DVS_W      = 21;
    localparam int DIV_STEPS  = DVD_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [1:0] kind;
        logic       link_up;
        logic       has_error;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [1:0] mode;
        logic       error_active;
    } out_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } div_rsp_t;

endpackage

// ----- sv/status_led_pattern_generator_unit.sv -----
// ----------------------------------------------------------------------------
// Status LED pattern generator
// Event-driven four-mode status indicator that emits one RGB color per tick.
// ----------------------------------------------------------------------------
// Non-tick events give no result. A tick needs no division in connected
// mode or with an empty period, one when disconnected or in the error pause,
// and two when active or in the error flashes. Only one item is in flight at
// a time; the single divider, used up to twice per tick, sets the pace. Reset
// (aresetn low, synchronous) restores the register defaults, the disconnected
// mode and zero elapsed time.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_unit import slpg_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,

    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data
);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_FIRST = 3'd1;
    localparam logic [2:0] ST_WAIT1 = 3'd2;
    localparam logic [2:0] ST_WAIT2 = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    // Configuration registers.
    logic [9:0]  step_reg;
    logic [7:0]  bright_reg;
    logic [15:0] blink_reg;
    logic [15:0] pulse_reg;
    logic [15:0] on_reg;
    logic [15:0] off_reg;
    logic [15:0] pause_reg;
    logic [3:0]  fcnt_reg;

    // Indicator state.
    logic [1:0]  mode_reg, mode_next;
    logic [31:0] elapsed_reg, elapsed_next;

    // Sequencer and result holding.
    logic [2:0]       state_reg, state_next;
    logic [DVS_W-1:0] flash_end_reg, flash_end_next;
    logic [7:0]       red_reg, red_next;
    logic [7:0]       green_reg, green_next;
    logic [7:0]       blue_reg, blue_next;
    logic             m_valid_reg, m_valid_next;
    out_t             m_data_reg, m_data_next;

    div_req_t div_req;
    div_rsp_t div_rsp;

    // Derived quantities of the current configuration. The flash slot is one
    // on time plus one off time, and one error cycle is the flash run plus
    // the dark pause; both fit the divisor width without wrapping.
    logic [16:0]      slot_c;
    logic [DVS_W-1:0] flash_end_c;
    logic [DVS_W-1:0] cycle_c;
    logic [14:0]      half_c;
    logic [15:0]      phase16_c;
    logic [15:0]      dist_c;
    logic [23:0]      num_c;
    logic [7:0]       lvl_c;
    logic             accept;

    assign slot_c      = {1'b0, on_reg} + {1'b0, off_reg};
    assign flash_end_c = DVS_W'(fcnt_reg) * DVS_W'(slot_c);
    assign cycle_c     = flash_end_c + DVS_W'(pause_reg);
    assign half_c      = pulse_reg[15:1];

    // The pulse phase is a remainder below the pulse period, so 16 bits hold
    // it. The falling half of the triangle mirrors around the period end.
    assign phase16_c = div_rsp.rem[15:0];
    assign dist_c    = (phase16_c <= {1'b0, half_c}) ? phase16_c : (pulse_reg - phase16_c);
    assign num_c     = dist_c * bright_reg;

    // The quotient never exceeds the brightness, so its low byte is the level.
    assign lvl_c = (div_rsp.quot[7:0] < MIN_GLOW) ? MIN_GLOW : div_rsp.quot[7:0];

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    slpg_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        elapsed_next   = elapsed_reg;
        flash_end_next = flash_end_reg;
        red_next       = red_reg;
        green_next     = green_reg;
        blue_next      = blue_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        div_req        = '0;

        // The output register frees up as soon as the consumer takes the
        // transfer, independently of the sequencer.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.kind)
                        KIND_TICK: begin
                            elapsed_next = elapsed_reg + 32'(step_reg);
                            red_next     = '0;
                            green_next   = '0;
                            blue_next    = '0;
                            state_next   = ST_FIRST;
                        end
                        KIND_LINK: begin
                            // Link events do not disturb an active or error
                            // indication.
                            if (!(mode_reg inside {MODE_ACTIVE, MODE_ERROR})) begin
                                mode_next = s_data.link_up ? MODE_CONN : MODE_DISC;
                            end
                        end
                        KIND_CONV: begin
                            mode_next = MODE_ACTIVE;
                        end
                        default: begin
                            if (s_data.has_error) begin
                                mode_next = MODE_ERROR;
                            end else begin
                                mode_next = s_data.link_up ? MODE_CONN : MODE_DISC;
                            end
                        end
                    endcase
                end
            end

            ST_FIRST: begin
                // The elapsed time already includes this tick's step.
                case (mode_reg)
                    MODE_DISC: begin
                        // A zero period leaves the LEDs dark.
                        if (blink_reg == '0) begin
                            state_next = ST_OUT;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = elapsed_reg;
                            div_req.divisor  = DVS_W'(blink_reg);
                            state_next       = ST_WAIT1;
                        end
                    end
                    MODE_CONN: begin
                        green_next = bright_reg;
                        state_next = ST_OUT;
                    end
                    MODE_ACTIVE: begin
                        // With an empty half period only the minimum glow
                        // remains.
                        if (half_c == '0) begin
                            green_next = MIN_GLOW;
                            blue_next  = MIN_GLOW;
                            state_next = ST_OUT;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = elapsed_reg;
                            div_req.divisor  = DVS_W'(pulse_reg);
                            state_next       = ST_WAIT1;
                        end
                    end
                    default: begin
                        flash_end_next = flash_end_c;
                        // An empty error cycle puts the phase at zero, where
                        // no flash can be lit because the flash run is empty.
                        if (cycle_c == '0) begin
                            state_next = ST_OUT;
                        end else begin
                            div_req.start    = 1'b1;
                            div_req.dividend = elapsed_reg;
                            div_req.divisor  = cycle_c;
                            state_next       = ST_WAIT1;
                        end
                    end
                endcase
            end

            ST_WAIT1: begin
                if (div_rsp.done) begin
                    case (mode_reg)
                        MODE_DISC: begin
                            // On for the first half of the blink period.
                            if (div_rsp.rem < DVS_W'(blink_reg[15:1])) begin
                                red_next = bright_reg;
                            end
                            state_next = ST_OUT;
                        end
                        MODE_ACTIVE: begin
                            div_req.start    = 1'b1;
                            div_req.dividend = DVD_W'(num_c);
                            div_req.divisor  = DVS_W'(half_c);
                            state_next       = ST_WAIT2;
                        end
                        default: begin
                            // Past the flash run the cycle is in its dark
                            // pause; otherwise find the place in the slot.
                            if (slot_c == '0 || div_rsp.rem >= flash_end_reg) begin
                                state_next = ST_OUT;
                            end else begin
                                div_req.start    = 1'b1;
                                div_req.dividend = DVD_W'(div_rsp.rem);
                                div_req.divisor  = DVS_W'(slot_c);
                                state_next       = ST_WAIT2;
                            end
                        end
                    endcase
                end
            end

            ST_WAIT2: begin
                if (div_rsp.done) begin
                    if (mode_reg == MODE_ACTIVE) begin
                        green_next = lvl_c;
                        blue_next  = lvl_c;
                    end else if (div_rsp.rem < DVS_W'(on_reg)) begin
                        red_next = bright_reg;
                    end
                    state_next = ST_OUT;
                end
            end

            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.red          = red_reg;
                    m_data_next.green        = green_reg;
                    m_data_next.blue         = blue_reg;
                    m_data_next.mode         = mode_reg;
                    m_data_next.error_active = (mode_reg == MODE_ERROR);
                    state_next               = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The user must write the configuration only while the block is idle; the block itself does not enforce it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= RST_STEP;
            bright_reg <= RST_BRIGHTNESS;
            blink_reg  <= RST_BLINK;
            pulse_reg  <= RST_PULSE;
            on_reg     <= RST_FLASH_ON;
            off_reg    <= RST_FLASH_OFF;
            pause_reg  <= RST_PAUSE;
            fcnt_reg   <= RST_FLASH_CNT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_STEP:       step_reg   <= cfg_wdata[9:0];
                CFG_BRIGHTNESS: bright_reg <= cfg_wdata[7:0];
                CFG_BLINK:      blink_reg  <= cfg_wdata;
                CFG_PULSE:      pulse_reg  <= cfg_wdata;
                CFG_FLASH_ON:   on_reg     <= cfg_wdata;
                CFG_FLASH_OFF:  off_reg    <= cfg_wdata;
                CFG_PAUSE:      pause_reg  <= cfg_wdata;
                CFG_FLASH_CNT:  fcnt_reg   <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_DISC;
            elapsed_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mode_reg    <= mode_next;
            elapsed_reg <= elapsed_next;
            m_valid_reg <= m_valid_next;
        end
        flash_end_reg <= flash_end_next;
        red_reg       <= red_next;
        green_reg     <= green_next;
        blue_reg      <= blue_next;
        m_data_reg    <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Only a tick moves the elapsed time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.kind != KIND_TICK |=> $stable(elapsed_reg))
        else $error("elapsed time changed on a non-tick event");

    // An accepted tick always moves the sequencer into its first step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.kind == KIND_TICK |=> state_reg == ST_FIRST)
        else $error("tick did not start the sequencer");

    // The error flag tracks the reported mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.error_active == (m_data.mode == MODE_ERROR))
        else $error("error flag disagrees with mode");

    // Connected mode is pure green.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.mode == MODE_CONN |-> m_data.red == '0 && m_data.blue == '0)
        else $error("connected color not pure green");

    // The active pulse is cyan and never below the minimum glow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.mode == MODE_ACTIVE |->
            m_data.green == m_data.blue && m_data.green >= MIN_GLOW && m_data.red == '0)
        else $error("active pulse color out of shape");

endmodule

// ----- sv/slpg_div.sv -----
// ----------------------------------------------------------------------------
// Pattern generator divider
// Restoring unsigned divider that retires two quotient bits per cycle.
// ----------------------------------------------------------------------------
module slpg_div import slpg_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVS_W-1:0]     rem_reg, rem_next;
    logic [DVD_W-1:0]     dq_reg, dq_next;
    logic [DVS_W-1:0]     dvs_reg, dvs_next;

    logic [DVS_W:0] d_ext, r1, s1, r2, s2;
    logic           ge1, ge2;

    // Two dependent shift-subtract steps per cycle.
    always_comb begin
        d_ext = {1'b0, dvs_reg};
        r1    = {rem_reg, dq_reg[DVD_W-1]};
        ge1   = (r1 >= d_ext);
        s1    = ge1 ? (r1 - d_ext) : r1;
        r2    = {s1[DVS_W-1:0], dq_reg[DVD_W-2]};
        ge2   = (r2 >= d_ext);
        s2    = ge2 ? (r2 - d_ext) : r2;
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            rem_next = s2[DVS_W-1:0];
            dq_next  = {dq_reg[DVD_W-3:0], ge1, ge2};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = dq_reg;
    assign rsp.rem  = rem_reg;

endmodule

// ----- test/status_led_pattern_generator_unit_test.sv -----
// ----------------------------------------------------------------------------
// Status LED pattern generator testbench
// Drives event transfers into the pattern generator and checks every color
// result against a cycle-free prediction of the mode and elapsed time. It runs
// directed mode changes and corner settings, then random event bursts under
// several register settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module status_led_pattern_generator_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import slpg_pkg::*;

    localparam int RESET_CYCLES = 5;
    // This covers any event still in flight once the last expected color has
    // arrived.
    localparam int DRAIN_CYCLES = 40;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 700;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_STEP;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;

    status_led_pattern_generator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // 20 ns clock period.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predicted state of the indicator. The register copies hold exactly the
    // bits the hardware keeps, so wide writes are masked on the way in.
    // ------------------------------------------------------------------------
    logic [9:0]  set_step   = RST_STEP;
    logic [7:0]  set_bright = RST_BRIGHTNESS;
    logic [15:0] set_blink  = RST_BLINK;
    logic [15:0] set_pulse  = RST_PULSE;
    logic [15:0] set_on     = RST_FLASH_ON;
    logic [15:0] set_off    = RST_FLASH_OFF;
    logic [15:0] set_pause  = RST_PAUSE;
    logic [3:0]  set_count  = RST_FLASH_CNT;
    logic [1:0]  led_mode   = MODE_DISC;
    logic [31:0] elapsed    = '0;

    // Colors predicted for ticks that were accepted but not yet seen leaving.
    out_t colors [$];
    out_t head_color;

    int          mismatches   = 0;
    int          stall_cycles = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;

    // A zero divisor gives a zero phase instead of a division fault.
    function automatic logic [31:0] mod_or_zero(input logic [31:0] a, input logic [31:0] m);
        return (m == 0) ? 32'd0 : a % m;
    endfunction

    function automatic logic [7:0] scale_channel(input logic [31:0] c, input logic [31:0] b);
        logic [31:0] p;
        p = (c * b) / 255;
        return p[7:0];
    endfunction

    // Triangle pulse: rises to the brightness at half period, falls back to
    // zero, and never goes below the minimum glow.
    function automatic logic [7:0] pulse_level(input logic [31:0] t);
        logic [31:0] period;
        logic [31:0] phase;
        logic [31:0] half;
        logic [31:0] bright;
        logic [31:0] lvl;
        period = set_pulse;
        bright = set_bright;
        phase  = mod_or_zero(t, period);
        half   = period / 2;
        if (half == 0) begin
            lvl = 0;
        end else if (phase <= half) begin
            lvl = (phase * bright) / half;
        end else begin
            lvl = ((period - phase) * bright) / half;
        end
        if (lvl < MIN_GLOW) begin
            lvl = MIN_GLOW;
        end
        return lvl[7:0];
    endfunction

    // Error cycle: flash_count pairs of on and off time, then the pause.
    function automatic logic flash_lit(input logic [31:0] t);
        logic [31:0] on_ms;
        logic [31:0] off_ms;
        logic [31:0] cycle_len;
        logic [31:0] phase;
        logic [31:0] start;
        on_ms     = set_on;
        off_ms    = set_off;
        cycle_len = set_count * (on_ms + off_ms) + set_pause;
        phase     = mod_or_zero(t, cycle_len);
        start     = 0;
        for (int i = 0; i < set_count; i++) begin
            if (phase >= start && phase < start + on_ms) return 1'b1;
            start = start + on_ms;
            if (phase >= start && phase < start + off_ms) return 1'b0;
            start = start + off_ms;
        end
        return 1'b0;
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_STEP:       set_step   = data[9:0];
            CFG_BRIGHTNESS: set_bright = data[7:0];
            CFG_BLINK:      set_blink  = data;
            CFG_PULSE:      set_pulse  = data;
            CFG_FLASH_ON:   set_on     = data;
            CFG_FLASH_OFF:  set_off    = data;
            CFG_PAUSE:      set_pause  = data;
            CFG_FLASH_CNT:  set_count  = data[3:0];
            default: ;
        endcase
    endfunction

    // Advances the predicted state by one accepted event. Only a tick leaves
    // a color behind to be checked.
    function automatic void record_event(input in_t ev);
        out_t c;
        logic [31:0] blink_phase;
        logic [7:0]  lvl;
        c = '0;
        case (ev.kind)
            KIND_LINK: begin
                // Link changes do not override a conversation or an error.
                if (led_mode != MODE_ACTIVE && led_mode != MODE_ERROR) begin
                    led_mode = ev.link_up ? MODE_CONN : MODE_DISC;
                end
            end
            KIND_CONV: begin
                led_mode = MODE_ACTIVE;
            end
            KIND_COMPLETE: begin
                led_mode = ev.has_error ? MODE_ERROR : (ev.link_up ? MODE_CONN : MODE_DISC);
            end
            KIND_TICK: begin
                elapsed = elapsed + set_step;
                case (led_mode)
                    MODE_DISC: begin
                        // Red during the first half of each blink period.
                        blink_phase = mod_or_zero(elapsed, set_blink);
                        if (blink_phase < set_blink / 2) begin
                            c.red = scale_channel(255, set_bright);
                        end
                    end
                    MODE_CONN: begin
                        c.green = scale_channel(255, set_bright);
                    end
                    MODE_ACTIVE: begin
                        lvl     = pulse_level(elapsed);
                        c.green = scale_channel(255, lvl);
                        c.blue  = scale_channel(255, lvl);
                    end
                    default: begin
                        if (flash_lit(elapsed)) begin
                            c.red = scale_channel(255, set_bright);
                        end
                    end
                endcase
                c.mode         = led_mode;
                c.error_active = (led_mode == MODE_ERROR);
                colors.push_back(c);
            end
            default: ;
        endcase
    endfunction

    function automatic in_t make_event(input logic [1:0] kind, input logic link,
                                       input logic err);
        in_t ev;
        ev.kind      = kind;
        ev.link_up   = link;
        ev.has_error = err;
        return ev;
    endfunction

    // ------------------------------------------------------------------------
    // Driving side. Every task is entered right after a rising edge and
    // returns right after one, so all updates land as nonblocking assignments
    // at the edge.
    // ------------------------------------------------------------------------

    // Sends one event, with a random number of idle cycles in front of it.
    // Valid is only lowered when an idle cycle is actually taken, so back to
    // back transfers keep it high without a glitch.
    task automatic send_event(input in_t ev);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
        record_event(ev);
    endtask

    task automatic send_tick();
        send_event(make_event(KIND_TICK, 1'($urandom), 1'($urandom)));
    endtask

    // Lets every outstanding color come back, then gives any event without a
    // result time to finish, so the block is idle afterwards.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (colors.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Leaves the write enable high; program_settings drops it after the last
    // write, so consecutive writes follow back to back without a gap.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        apply_register(idx, data);
    endtask

    task automatic program_settings(input logic [CFG_DATA_W-1:0] step,
                                    input logic [CFG_DATA_W-1:0] bright,
                                    input logic [CFG_DATA_W-1:0] blink,
                                    input logic [CFG_DATA_W-1:0] pulse,
                                    input logic [CFG_DATA_W-1:0] on_ms,
                                    input logic [CFG_DATA_W-1:0] off_ms,
                                    input logic [CFG_DATA_W-1:0] pause,
                                    input logic [CFG_DATA_W-1:0] count);
        wait_idle();
        write_register(CFG_STEP, step);
        write_register(CFG_BRIGHTNESS, bright);
        write_register(CFG_BLINK, blink);
        write_register(CFG_PULSE, pulse);
        write_register(CFG_FLASH_ON, on_ms);
        write_register(CFG_FLASH_OFF, off_ms);
        write_register(CFG_PAUSE, pause);
        write_register(CFG_FLASH_CNT, count);
        cfg_wr_en <= 1'b0;
    endtask

    // Mostly moderate periods so that elapsed time sweeps through several
    // blink, pulse and error cycles; now and then a full 16-bit raw value,
    // which also sets the bits above the narrower registers.
    task automatic program_random_settings();
        logic [CFG_DATA_W-1:0] step;
        logic [CFG_DATA_W-1:0] bright;
        logic [CFG_DATA_W-1:0] blink;
        logic [CFG_DATA_W-1:0] pulse;
        logic [CFG_DATA_W-1:0] on_ms;
        logic [CFG_DATA_W-1:0] off_ms;
        logic [CFG_DATA_W-1:0] pause;
        logic [CFG_DATA_W-1:0] count;
        step   = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(1, 300));
        bright = 16'($urandom);
        blink  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2, 3000));
        pulse  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2, 3000));
        on_ms  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 800));
        off_ms = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 800));
        pause  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2500));
        count  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 15));
        program_settings(step, bright, blink, pulse, on_ms, off_ms, pause, count);
    endtask

    // Random traffic is shaped as bursts: one event of any kind, usually a
    // mode change, followed by a run of ticks that shows the pattern of the
    // new mode as elapsed time moves on.
    task automatic run_event_bursts(input int count);
        int          sent;
        int unsigned pick;
        in_t         ev;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            ev   = make_event(KIND_TICK, 1'($urandom), ($urandom_range(2) == 0));
            if (pick < 20) begin
                ev.kind = KIND_LINK;
            end else if (pick < 40) begin
                ev.kind = KIND_CONV;
            end else if (pick < 70) begin
                ev.kind = KIND_COMPLETE;
            end
            send_event(ev);
            sent++;
            repeat ($urandom_range(1, 12)) begin
                send_tick();
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Steps through every mode and every event kind under the reset settings,
    // including link changes that must be ignored while active or in error.
    task automatic test_mode_transitions();
        send_tick();
        send_event(make_event(KIND_LINK, 1'b1, 1'b0));
        send_tick();
        send_event(make_event(KIND_LINK, 1'b0, 1'b1));
        send_tick();
        send_event(make_event(KIND_CONV, 1'b0, 1'b0));
        send_tick();
        send_event(make_event(KIND_LINK, 1'b1, 1'b0));
        send_tick();
        send_event(make_event(KIND_COMPLETE, 1'b1, 1'b1));
        send_tick();
        send_event(make_event(KIND_LINK, 1'b0, 1'b0));
        send_tick();
        send_event(make_event(KIND_COMPLETE, 1'b1, 1'b0));
        send_tick();
        send_event(make_event(KIND_COMPLETE, 1'b0, 1'b0));
        send_tick();
    endtask

    // Corner settings: periods of zero and one, a dim brightness under the
    // minimum glow, an empty flash run with a zero-length error cycle, and
    // oversized writes that must be cut to the register widths.
    task automatic test_special_cases();
        // Step and flash count are written with bits above their width.
        program_settings(16'hFFFF, 16'd5, 16'd1, 16'd1, 16'd200, 16'd150, 16'd0, 16'h0010);
        send_tick();
        send_event(make_event(KIND_CONV, 1'b1, 1'b0));
        send_tick();
        send_event(make_event(KIND_COMPLETE, 1'b0, 1'b1));
        send_tick();

        // Full brightness, zero periods, and the longest possible error cycle.
        program_settings(16'd1, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_tick();
        send_event(make_event(KIND_COMPLETE, 1'b0, 1'b0));
        send_tick();
        send_event(make_event(KIND_CONV, 1'b0, 1'b1));
        send_tick();
    endtask

    // Random bursts in three idling patterns, two register settings each; the
    // first two patterns open with the low and the high extremes, the rest is random.
    task automatic test_random_traffic();
        for (int lane = 0; lane < 3; lane++) begin
            case (lane)
                0: begin
                    src_idle_pct  = 38;
                    sink_idle_pct = 67;
                end
                1: begin
                    src_idle_pct  = 67;
                    sink_idle_pct = 38;
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int half = 0; half < 2; half++) begin
                if (lane == 0 && half == 0) begin
                    program_settings(16'd1, 16'd0, 16'd2, 16'd2, 16'd1, 16'd1, 16'd0, 16'd1);
                end else if (lane == 1 && half == 0) begin
                    program_settings(16'd1023, 16'd255, 16'hFFFF, 16'hFFFF,
                                     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd15);
                end else begin
                    program_random_settings();
                end
                run_event_bursts(RANDOM_ITEMS / 6);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver, checker and watchdog
    // ------------------------------------------------------------------------

    // The result channel is stalled at random at the current idle rate.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Each accepted color is matched against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (colors.size() == 0) begin
                $display("%0t: unexpected color r=%0d g=%0d b=%0d mode=%0d err=%0b",
                         $time, m_data.red, m_data.green, m_data.blue, m_data.mode,
                         m_data.error_active);
                mismatches++;
            end else begin
                head_color = colors.pop_front();
                if (m_data.red !== head_color.red || m_data.green !== head_color.green ||
                    m_data.blue !== head_color.blue || m_data.mode !== head_color.mode ||
                    m_data.error_active !== head_color.error_active) begin
                    $display("%0t: expected r=%0d g=%0d b=%0d mode=%0d err=%0b, got r=%0d g=%0d b=%0d mode=%0d err=%0b",
                             $time, head_color.red, head_color.green, head_color.blue,
                             head_color.mode, head_color.error_active, m_data.red,
                             m_data.green, m_data.blue, m_data.mode, m_data.error_active);
                    mismatches++;
                end
            end
        end
    end

    // Any transfer on either channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        src_idle_pct  = 38;
        sink_idle_pct = 67;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_mode_transitions();
        test_special_cases();
        test_random_traffic();

        wait_idle();
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
